// ===== rtl/spd_pkg.sv =====
package spd_pkg;

  // Defaults for the top level parameters.
  localparam int NUM_PACKETS_DEF = 15;
  localparam int HEADER_SIZE_DEF = 16;
  localparam int LENGTH_BITS_DEF = 16;

  // Header byte codes.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [3:0] DIGIT_MASK = 4'hF;
  localparam logic [7:0] TERMINATOR = 8'h00;

  // Width of the mask register; it covers the ids below this value.
  localparam int MASK_BITS = 16;

  // Parser state, one-hot.
  typedef enum logic [1:0] {
    ST_HEADER  = 2'b01,
    ST_PAYLOAD = 2'b10
  } parse_state_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  packet_id;
    logic [15:0] byte_index;
    logic        last_byte;
    logic        deliver;
    logic        empty_packet;
  } result_t;

  // Handshake state of the input register toward the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } stage_t;

endpackage

// ===== rtl/spd_in_reg.sv =====
module spd_in_reg import spd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       go,
  output stage_t     stage
);

  logic       valid;
  logic [7:0] held_byte;

  // The register frees up in the same cycle that its byte moves on.
  assign in_ready = !valid || go;

  // Valid flag of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (go) begin
      valid <= 1'b0;
    end
  end

  // Byte captured on each input transfer.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

  assign stage.valid   = valid;
  assign stage.rx_byte = held_byte;

endmodule

// ===== rtl/spd_parser.sv =====
module spd_parser import spd_pkg::*; #(
  parameter int NUM_PACKETS = NUM_PACKETS_DEF,
  parameter int HEADER_SIZE = HEADER_SIZE_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  input  logic [MASK_BITS-1:0]   mask,
  output logic                   res_valid,
  output result_t                res
);

  localparam int HPOS_W = $clog2(HEADER_SIZE + 1);
  localparam int PROD_W = LENGTH_BITS + 4;

  parse_state_t           state, state_next;
  logic [HPOS_W-1:0]      header_pos, header_pos_next;
  logic [7:0]             current_id, current_id_next;
  logic [LENGTH_BITS-1:0] payload_length, payload_length_next;
  logic [LENGTH_BITS-1:0] payload_pos, payload_pos_next;

  logic [HPOS_W-1:0]      pos_eff;
  logic                   at_id;
  logic [7:0]             id_eff;
  logic [LENGTH_BITS-1:0] len_eff;
  logic [3:0]             digit;
  logic [PROD_W-1:0]      len_ext;
  logic [PROD_W-1:0]      len_acc;
  logic [LENGTH_BITS-1:0] len_sat;
  logic                   last;
  logic [7:0]             res_id;
  logic                   id_ok;

  // A header that has run past its buffer starts over at the id byte.
  assign pos_eff = (header_pos >= HPOS_W'(HEADER_SIZE)) ? '0 : header_pos;
  assign at_id   = (pos_eff == '0);
  assign id_eff  = at_id ? 8'h00 : current_id;
  assign len_eff = at_id ? '0 : payload_length;

  // Decimal accumulation: length * 10 + digit, saturating.
  assign digit   = 4'(rx_byte - CHAR_ZERO) & DIGIT_MASK;
  assign len_ext = PROD_W'(len_eff);
  assign len_acc = (len_ext << 3) + (len_ext << 1) + PROD_W'(digit);
  assign len_sat = (len_acc[PROD_W-1:LENGTH_BITS] != '0) ? '1 : len_acc[LENGTH_BITS-1:0];

  // Final payload byte when the next position reaches the length.
  assign last = ({1'b0, payload_pos} + 1'b1) == {1'b0, payload_length};

  // Id that goes with the result and its deliver decision.
  assign res_id = (state == ST_HEADER) ? id_eff : current_id;
  assign id_ok  = (res_id != 8'h00) && (res_id <= 8'(NUM_PACKETS)) &&
                  (res_id < 8'(MASK_BITS));

  // Next state and result.
  always_comb begin
    state_next          = state;
    header_pos_next     = header_pos;
    current_id_next     = current_id;
    payload_length_next = payload_length;
    payload_pos_next    = payload_pos;
    res_valid           = 1'b0;
    res.data_byte       = rx_byte;
    res.packet_id       = res_id;
    res.byte_index      = 16'(payload_pos);
    res.last_byte       = last;
    res.deliver         = id_ok && mask[res_id[3:0]];
    res.empty_packet    = 1'b0;
    case (state)
      ST_HEADER: begin
        current_id_next     = id_eff;
        payload_length_next = len_eff;
        if (rx_byte == TERMINATOR) begin
          header_pos_next  = '0;
          payload_pos_next = '0;
          if (len_eff == '0) begin
            // Zero length header: one empty result, stay in the header.
            res_valid        = 1'b1;
            res.data_byte    = 8'h00;
            res.byte_index   = 16'h0000;
            res.last_byte    = 1'b1;
            res.empty_packet = 1'b1;
          end else begin
            state_next = ST_PAYLOAD;
          end
        end else begin
          if (at_id) begin
            current_id_next = rx_byte;
          end else begin
            payload_length_next = len_sat;
          end
          header_pos_next = pos_eff + 1'b1;
        end
      end
      ST_PAYLOAD: begin
        res_valid = 1'b1;
        if (last) begin
          state_next       = ST_HEADER;
          header_pos_next  = '0;
          payload_pos_next = '0;
        end else begin
          payload_pos_next = payload_pos + 1'b1;
        end
      end
      default: begin
        state_next = ST_HEADER;
      end
    endcase
  end

  // Parser state advances once for each byte taken from the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_HEADER;
      header_pos     <= '0;
      current_id     <= 8'h00;
      payload_length <= '0;
      payload_pos    <= '0;
    end else if (step) begin
      state          <= state_next;
      header_pos     <= header_pos_next;
      current_id     <= current_id_next;
      payload_length <= payload_length_next;
      payload_pos    <= payload_pos_next;
    end
  end

endmodule

// ===== rtl/spd_out_reg.sv =====
module spd_out_reg import spd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t held
);

  logic valid, valid_next;

  // A new result may only be loaded once the old one has gone.
  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (out_ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign out_valid = valid;

endmodule

// ===== rtl/serial_packet_deframer.sv =====
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    rx_byte
// output    out        out_valid / out_ready  data_byte, packet_id, byte_index,
//                                             last_byte, deliver, empty_packet
// config    in         cfg_valid / cfg_ready  registered_mask
//
// One byte is taken per cycle while the output is not stalled. A byte waits in the
// input register and is parsed into the output register when it moves on, so a
// result passes through both registers. The parser state update is the only loop.
// Header bytes other than the terminator give no result.
// Reset clears the parser to the start of a header and the mask to zero.
// A stalled output holds the input register, which then takes no new byte.
module serial_packet_deframer import spd_pkg::*; #(
  parameter int NUM_PACKETS = NUM_PACKETS_DEF,
  parameter int HEADER_SIZE = HEADER_SIZE_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic [7:0]  packet_id,
  output logic [15:0] byte_index,
  output logic        last_byte,
  output logic        deliver,
  output logic        empty_packet,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] registered_mask
);

  logic [MASK_BITS-1:0] mask;
  stage_t               stage;
  logic                 go;
  logic                 res_valid;
  result_t              res;
  result_t              held;

  // Mask register, written on each config transfer.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      mask <= registered_mask;
    end
  end

  // A byte moves on when the output register is free or being emptied.
  assign go = stage.valid && (!out_valid || out_ready);

  spd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .go       (go),
    .stage    (stage)
  );

  spd_parser #(
    .NUM_PACKETS (NUM_PACKETS),
    .HEADER_SIZE (HEADER_SIZE),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (go),
    .rx_byte   (stage.rx_byte),
    .mask      (mask),
    .res_valid (res_valid),
    .res       (res)
  );

  spd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (go && res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign data_byte    = held.data_byte;
  assign packet_id    = held.packet_id;
  assign byte_index   = held.byte_index;
  assign last_byte    = held.last_byte;
  assign deliver      = held.deliver;
  assign empty_packet = held.empty_packet;

  // An empty packet result is a lone final item with zeroed data and index.
  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_packet |-> last_byte && data_byte == 8'h00 && byte_index == 16'h0000)
    else $error("empty packet result with data, index or no last mark");

  // Input stalls only while a byte waits behind a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> stage.valid && out_valid && !out_ready)
    else $error("input stalled without a blocked output");

  // Deliver never reported for id zero.
  a_deliver_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_id == 8'h00 |-> !deliver)
    else $error("deliver set for id zero");

  // Nothing is presented right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== tb/deframer_checker.sv =====
// Watches the input, configuration and output channels of the deframer.
// It keeps its own copy of the header parser and the handler mask, predicts
// the result of every accepted byte, and compares each output transfer with
// the oldest prediction.
module deframer_checker import spd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  packet_id,
  input  logic [15:0] byte_index,
  input  logic        last_byte,
  input  logic        deliver,
  input  logic        empty_packet,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] registered_mask,
  output int          errors,
  output int          pending,
  output int          results_seen,
  output int          empties_seen,
  output int          deliveries_seen
);

  localparam longint unsigned LEN_LIMIT = (64'd1 << LENGTH_BITS_DEF) - 1;

  // Predicted parser state and handler mask.
  bit               hdr_active;
  int unsigned      hdr_pos;
  logic [7:0]       frame_id;
  longint unsigned  frame_len;
  longint unsigned  frame_pos;
  logic [15:0]      handler_mask;

  // Results predicted but not yet seen on the output channel.
  result_t          predicted_results [$];

  result_t          seen;
  result_t          want;
  result_t          predicted;

  // Builds one result for the current frame, including the deliver flag.
  function automatic result_t frame_result(input logic [7:0] data, input logic [15:0] index,
                                           input logic last, input logic empty);
    result_t r;
    r.data_byte    = data;
    r.packet_id    = frame_id;
    r.byte_index   = index;
    r.last_byte    = last;
    r.empty_packet = empty;
    r.deliver      = (frame_id >= 1) && (frame_id <= NUM_PACKETS_DEF) &&
                     (frame_id < MASK_BITS) && handler_mask[frame_id % MASK_BITS];
    return r;
  endfunction

  // Advances the parser by one received byte. Returns 1 when the byte
  // produces a result, which is then placed in r.
  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    longint unsigned acc;
    r = '0;
    if (hdr_active) begin
      // A full header wraps around, so this byte starts a new header.
      if (hdr_pos >= HEADER_SIZE_DEF) hdr_pos = 0;
      if (hdr_pos == 0) begin
        frame_id  = '0;
        frame_len = 0;
      end
      if (b == TERMINATOR) begin
        hdr_pos   = 0;
        frame_pos = 0;
        // A zero length header closes at once with one empty result.
        if (frame_len == 0) begin
          r = frame_result(8'h00, 16'h0000, 1'b1, 1'b1);
          return 1'b1;
        end
        hdr_active = 1'b0;
        return 1'b0;
      end
      if (hdr_pos == 0) begin
        frame_id = b;
      end else begin
        acc = frame_len * 10 + ((b - CHAR_ZERO) & DIGIT_MASK);
        frame_len = (acc > LEN_LIMIT) ? LEN_LIMIT : acc;
      end
      hdr_pos++;
      return 1'b0;
    end

    // Payload byte: every one of them gives a result.
    r = frame_result(b, 16'(frame_pos), 1'(frame_pos + 1 >= frame_len), 1'b0);
    if (frame_pos + 1 >= frame_len) begin
      frame_pos  = 0;
      hdr_active = 1'b1;
      hdr_pos    = 0;
    end else begin
      frame_pos++;
    end
    return 1'b1;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(input string field, input int unsigned expected_value,
                             input int unsigned actual_value);
    if (expected_value != actual_value) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, expected_value,
             actual_value);
      errors++;
    end
  endtask

  // All channels are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      hdr_active      = 1'b1;
      hdr_pos         = 0;
      frame_id        = '0;
      frame_len       = 0;
      frame_pos       = 0;
      handler_mask    = '0;
      errors          = 0;
      results_seen    = 0;
      empties_seen    = 0;
      deliveries_seen = 0;
      predicted_results.delete();
    end else begin
      // Compare an output transfer with the oldest prediction.
      if (out_valid && out_ready) begin
        seen = {data_byte, packet_id, byte_index, last_byte, deliver, empty_packet};
        results_seen++;
        if (seen.empty_packet) empties_seen++;
        if (seen.deliver) deliveries_seen++;
        if (predicted_results.size() == 0) begin
          $error("Result with no prediction waiting: data_byte 0x%0h, packet_id 0x%0h",
                 seen.data_byte, seen.packet_id);
          errors++;
        end else begin
          want = predicted_results.pop_front();
          check_field("data_byte", want.data_byte, seen.data_byte);
          check_field("packet_id", want.packet_id, seen.packet_id);
          check_field("byte_index", want.byte_index, seen.byte_index);
          check_field("last_byte", want.last_byte, seen.last_byte);
          check_field("deliver", want.deliver, seen.deliver);
          check_field("empty_packet", want.empty_packet, seen.empty_packet);
        end
      end

      if (cfg_valid && cfg_ready) handler_mask = registered_mask;

      // Predict the result of an input transfer.
      if (in_valid && in_ready) begin
        if (deframe_byte(rx_byte, predicted)) predicted_results.push_back(predicted);
      end
    end
    pending = predicted_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top import spd_pkg::*;;

  localparam int unsigned LEN_LIMIT   = (1 << LENGTH_BITS_DEF) - 1;
  localparam int          PHASE_BYTES = 200;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          CYCLE_LIMIT = 5_000_000;
  localparam int          SAT_PAYLOAD_BYTES = 32;

  // Shapes of byte sequences that the generator can produce.
  typedef enum int {
    FK_WELL_FORMED,
    FK_ODD_DIGITS,
    FK_OVERRUN,
    FK_BARE_TERMINATOR,
    FK_ZERO_LENGTH,
    FK_SATURATING
  } frame_kind_e;

  // Receiver behavior on the output channel.
  typedef enum int {
    RX_STEADY,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_e;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  data_byte;
  logic [7:0]  packet_id;
  logic [15:0] byte_index;
  logic        last_byte;
  logic        deliver;
  logic        empty_packet;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] registered_mask;

  int          errors;
  int          pending;
  int          results_seen;
  int          empties_seen;
  int          deliveries_seen;

  int          bytes_sent;
  int          mask_writes;
  int          burst_left;
  int          cycle_count;
  rx_mode_e    rx_mode;
  int          rx_mode_left;
  int          rx_slot;
  logic [7:0]  directed_stream [$];
  logic [15:0] mask_plan [$];

  serial_packet_deframer dut (.*);

  deframer_checker checker_inst (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit for the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // The receiver switches between steady, random and sparse acceptance.
  initial begin
    rx_mode      = RX_STEADY;
    rx_mode_left = 0;
    rx_slot      = 0;
  end

  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      case ($urandom_range(0, 3))
        0: rx_mode = RX_RANDOM;
        1: rx_mode = RX_SPARSE;
        default: rx_mode = RX_STEADY;
      endcase
      rx_mode_left = $urandom_range(16, 96);
    end
    rx_mode_left--;
    rx_slot++;
    case (rx_mode)
      RX_RANDOM: out_ready <= $urandom_range(0, 1);
      RX_SPARSE: out_ready <= (rx_slot % 8 == 0);
      default:   out_ready <= 1'b1;
    endcase
  end

  // Offers one byte and returns at the falling edge after its transfer.
  // The sender works in bursts, often separated by idle gaps.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sends one header and its payload, or a broken header, of the given kind.
  task automatic send_packet(input frame_kind_e kind);
    logic [7:0]  id;
    logic [7:0]  digit_byte;
    logic [7:0]  header_digits [$];
    int unsigned value;
    int unsigned rest;
    int unsigned length;
    int          r;
    // Ids in the mask range dominate so that the deliver flag toggles often.
    id = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(1, NUM_PACKETS_DEF)) :
                                       8'($urandom_range(16, 255));
    value = 0;
    case (kind)
      FK_BARE_TERMINATOR: begin
        send_byte(TERMINATOR);
        return;
      end
      FK_OVERRUN: begin
        // Fill the header buffer without a terminator.
        send_byte(id);
        repeat (HEADER_SIZE_DEF - 1) send_byte(8'($urandom_range(1, 255)));
        return;
      end
      FK_ODD_DIGITS: begin
        // Arbitrary bytes in digit position; only their low nibble counts.
        repeat (($urandom_range(0, 9) < 7) ? 1 : 2) begin
          digit_byte = 8'($urandom_range(1, 255));
          header_digits.push_back(digit_byte);
          value = value * 10 + ((digit_byte - CHAR_ZERO) & DIGIT_MASK);
        end
      end
      FK_ZERO_LENGTH: value = 0;
      // Just past the maximum, so a length that wrapped would end the packet early.
      FK_SATURATING:  value = $urandom_range(LEN_LIMIT + 1, LEN_LIMIT + 25);
      default: begin
        r = $urandom_range(0, 99);
        if (r < 75)      value = $urandom_range(1, 8);
        else if (r < 92) value = $urandom_range(9, 40);
        else             value = $urandom_range(41, 300);
      end
    endcase

    // Write the length as decimal text, sometimes with leading zeros.
    if (kind != FK_ODD_DIGITS) begin
      rest = value;
      do begin
        header_digits.push_front(CHAR_ZERO + 8'(rest % 10));
        rest = rest / 10;
      end while (rest != 0);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) header_digits.push_front(CHAR_ZERO);
      end
    end
    length = (value > LEN_LIMIT) ? LEN_LIMIT : value;
    // Only the opening bytes of a saturated payload are sent.
    if (kind == FK_SATURATING) length = SAT_PAYLOAD_BYTES;

    send_byte(id);
    foreach (header_digits[i]) send_byte(header_digits[i]);
    send_byte(TERMINATOR);
    repeat (length) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Random sequences, mostly well-formed packets with random content.
  task automatic random_phase();
    int target;
    int r;
    target = bytes_sent + PHASE_BYTES;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 62)      send_packet(FK_WELL_FORMED);
      else if (r < 74) send_packet(FK_ODD_DIGITS);
      else if (r < 82) send_packet(FK_OVERRUN);
      else if (r < 90) send_packet(FK_BARE_TERMINATOR);
      else             send_packet(FK_ZERO_LENGTH);
    end
  endtask

  // Stops sending and waits until every predicted result has been checked.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes the handler mask while the block is idle.
  task automatic write_mask(input logic [15:0] m);
    cfg_valid       <= 1'b1;
    registered_mask <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mask_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus and verdict.
  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    rx_byte         = 8'h00;
    cfg_valid       = 1'b0;
    registered_mask = 16'h0000;
    bytes_sent      = 0;
    mask_writes     = 0;
    burst_left      = 0;

    // Directed bytes: a terminator as the id, a two byte payload holding
    // a zero byte, a zero length packet on the highest id, an id beyond the
    // mask, a letter in digit position, and an in-range id with no handler.
    directed_stream = '{TERMINATOR,
                        8'd3, CHAR_ZERO + 8'd2, TERMINATOR, 8'hFF, 8'h00,
                        8'd15, CHAR_ZERO, TERMINATOR,
                        8'd16, CHAR_ZERO + 8'd1, TERMINATOR, 8'h80,
                        8'hFF, 8'h41, TERMINATOR, 8'h01,
                        8'd2, CHAR_ZERO + 8'd1, TERMINATOR, 8'h7F};
    mask_plan = '{16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555,
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // First phase runs with the mask left at its reset value.
    random_phase();
    settle();

    // Directed part, then header overruns with and without a terminator.
    write_mask(16'h802A);
    foreach (directed_stream[i]) send_byte(directed_stream[i]);
    send_packet(FK_OVERRUN);
    send_packet(FK_BARE_TERMINATOR);
    send_packet(FK_OVERRUN);
    send_packet(FK_WELL_FORMED);
    settle();

    foreach (mask_plan[i]) begin
      write_mask(mask_plan[i]);
      random_phase();
      settle();
    end

    // One packet whose length saturates at the maximum; its payload is cut short.
    send_packet(FK_SATURATING);
    settle();

    $display("Summary: %0d bytes sent under %0d mask settings, with header overruns",
             bytes_sent, mask_writes + 1);
    $display("and a saturated length; %0d results checked, %0d empty, %0d delivered.",
             results_seen, empties_seen, deliveries_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
